@@ design/ubrs_pkg.sv @@
// Package for the unit cube ray slab test: widths, pipeline depth, divider step.
// No dependencies; used by every other file of the block.
`default_nettype none
package ubrs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CORNER_W  = 16;
  localparam int ORIGIN_W  = 32;
  localparam int DIR_W     = 18;
  localparam int EPS_W     = 16;
  localparam int DIST_W    = 31;

  // slab numerator (bound - origin), signed
  localparam int BOUND_W = CORNER_W + FRAC_BITS + 1;
  localparam int NUM_W   = ((BOUND_W > ORIGIN_W) ? BOUND_W : ORIGIN_W) + 1;
  // divisor magnitude, dividend and quotient widths
  localparam int DEN_W   = DIR_W;
  localparam int DVD_W   = NUM_W + FRAC_BITS;
  localparam int BPS     = 7;
  localparam int DIV_ST  = (DVD_W + BPS - 1) / BPS;
  localparam int PAD_W   = DIV_ST * BPS;
  localparam int TW      = DVD_W + 1;
  // A, B, divider stages, order, near/far pair, near/far final, output
  localparam int NSTG    = DIV_ST + 6;

  localparam logic signed [TW-1:0] T_MIN    = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_MAX    = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] DIST_MAX = {{(TW-DIST_W){1'b0}}, {DIST_W{1'b1}}};

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [PAD_W-1:0] dvd;
  } div_t;

  // BPS restoring steps; quotient bits shift in at the bottom of dvd
  function automatic div_t div_step(input div_t s, input logic [DEN_W-1:0] den);
    div_t         r;
    logic [DEN_W:0] trial;
    r = s;
    for (int i = 0; i < BPS; i++) begin
      trial = {r.rem, r.dvd[PAD_W-1]};
      r.dvd = {r.dvd[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial    = trial - {1'b0, den};
        r.dvd[0] = 1'b1;
      end
      r.rem = trial[DEN_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/ubrs_if.sv @@
// Request and result channel interfaces for the ray slab test.
// Depends on ubrs_pkg for field widths.
`default_nettype none
interface ubrs_ray_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ubrs_pkg::CORNER_W-1:0]   block_x;
  logic signed [ubrs_pkg::CORNER_W-1:0]   block_y;
  logic signed [ubrs_pkg::CORNER_W-1:0]   block_z;
  logic signed [ubrs_pkg::ORIGIN_W-1:0]   origin_x;
  logic signed [ubrs_pkg::ORIGIN_W-1:0]   origin_y;
  logic signed [ubrs_pkg::ORIGIN_W-1:0]   origin_z;
  logic signed [ubrs_pkg::DIR_W-1:0]      dir_x;
  logic signed [ubrs_pkg::DIR_W-1:0]      dir_y;
  logic signed [ubrs_pkg::DIR_W-1:0]      dir_z;
  modport source (output valid, block_x, block_y, block_z, origin_x, origin_y, origin_z,
                  dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, block_x, block_y, block_z, origin_x, origin_y, origin_z,
                dir_x, dir_y, dir_z, output ready);
endinterface

interface ubrs_hit_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [ubrs_pkg::DIST_W-1:0]   distance;
  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface
`default_nettype wire

@@ design/unit_box_ray_slab_test.sv @@
// Ray against unit axis-aligned cube, slab method, fully pipelined.
// Depends on ubrs_pkg and the channel interfaces in ubrs_if.sv.
//
// Usage:
//   ray (sink): one request per accepted beat: cube corner, ray origin and
//     direction. res (source): one result per request, hit flag and distance.
//   cfg_we/cfg_data write dir_epsilon; write only while no request is in flight.
//   Results leave in request order through stages A, B, the divider stages,
//     E, F, G and H. Throughput: one request per cycle while res is not stalled.
//   The six restoring dividers (two per axis) are each split into DIV_ST
//     stages of 7 quotient bits.
//   All stages advance together; when res is stalled with a result waiting,
//     the whole pipe holds and ray.ready drops. Nothing is lost or repeated.
//   Reset (rst, synchronous) empties the pipe and sets dir_epsilon to 1.
//   Axes with |dir| <= dir_epsilon are skipped, or force a miss when the
//     origin lies outside that slab.
`default_nettype none
module unit_box_ray_slab_test (
  input  wire logic                        clk,
  input  wire logic                        rst,
  ubrs_ray_if.sink                         ray,
  ubrs_hit_if.source                       res,
  input  wire logic                        cfg_we,
  input  wire logic [ubrs_pkg::EPS_W-1:0]  cfg_data
);

  localparam int NUM_W  = ubrs_pkg::NUM_W;
  localparam int DEN_W  = ubrs_pkg::DEN_W;
  localparam int DVD_W  = ubrs_pkg::DVD_W;
  localparam int PAD_W  = ubrs_pkg::PAD_W;
  localparam int TW     = ubrs_pkg::TW;
  localparam int DIV_ST = ubrs_pkg::DIV_ST;
  localparam int NSTG   = ubrs_pkg::NSTG;
  localparam int FB     = ubrs_pkg::FRAC_BITS;

  logic [ubrs_pkg::EPS_W-1:0] eps;
  logic [NSTG-1:0]            pv;
  logic                       en;

  assign en        = !pv[NSTG-1] || res.ready;
  assign ray.ready = en;
  assign res.valid = pv[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= ubrs_pkg::EPS_W'(1);
      pv  <= '0;
    end else begin
      if (cfg_we) begin
        eps <= cfg_data;
      end
      if (en) begin
        pv <= {pv[NSTG-2:0], ray.valid};
      end
    end
  end

  // stage A: slab numerators, |dir|, parallel flag
  logic signed [NUM_W-1:0] a_num [3][2];
  logic [DEN_W-1:0]        a_dabs [3];
  logic                    a_dneg [3];
  logic                    a_par [3];

  logic signed [NUM_W-1:0] c_num [3][2];
  logic [DEN_W-1:0]        c_dabs [3];
  logic                    c_dneg [3];
  logic                    c_par [3];

  always_comb begin
    logic signed [ubrs_pkg::CORNER_W-1:0] bx [3];
    logic signed [ubrs_pkg::ORIGIN_W-1:0] ox [3];
    logic signed [ubrs_pkg::DIR_W-1:0]    dx [3];
    logic signed [NUM_W-1:0]              lo;
    logic signed [NUM_W-1:0]              org;
    bx[0] = ray.block_x;  bx[1] = ray.block_y;  bx[2] = ray.block_z;
    ox[0] = ray.origin_x; ox[1] = ray.origin_y; ox[2] = ray.origin_z;
    dx[0] = ray.dir_x;    dx[1] = ray.dir_y;    dx[2] = ray.dir_z;
    for (int k = 0; k < 3; k++) begin
      lo  = NUM_W'(bx[k]) <<< FB;
      org = NUM_W'(ox[k]);
      c_num[k][0] = lo - org;
      c_num[k][1] = lo - org + (NUM_W'(1) <<< FB);
      c_dneg[k]   = dx[k][DEN_W-1];
      c_dabs[k]   = c_dneg[k] ? DEN_W'(-dx[k]) : DEN_W'(dx[k]);
      c_par[k]    = c_dabs[k] <= DEN_W'(eps);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_num  <= c_num;
      a_dabs <= c_dabs;
      a_dneg <= c_dneg;
      a_par  <= c_par;
    end
  end

  // stage B and divider stages; index 0 is stage B
  ubrs_pkg::div_t   dv   [DIV_ST+1][6];
  logic [DEN_W-1:0] dden [DIV_ST+1][3];
  logic             dneg [DIV_ST+1][6];
  logic             dpar [DIV_ST+1][3];
  logic             dpm  [DIV_ST+1];

  ubrs_pkg::div_t   b_dv   [6];
  logic             b_neg  [6];
  logic             b_pm;

  always_comb begin
    logic [NUM_W-1:0] mag;
    logic             sgn;
    b_pm = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 2; j++) begin
        sgn            = a_num[k][j][NUM_W-1];
        mag            = sgn ? NUM_W'(-a_num[k][j]) : NUM_W'(a_num[k][j]);
        b_neg[2*k+j]   = sgn ^ a_dneg[k];
        b_dv[2*k+j].rem = '0;
        b_dv[2*k+j].dvd = PAD_W'({mag, {FB{1'b0}}});
      end
      // origin below lo: lo-o > 0; origin above hi: hi-o < 0
      if (a_par[k] && ((!a_num[k][0][NUM_W-1] && (a_num[k][0] != '0)) ||
                       a_num[k][1][NUM_W-1])) begin
        b_pm = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0]   <= b_dv;
      dneg[0] <= b_neg;
      dden[0] <= a_dabs;
      dpar[0] <= a_par;
      dpm[0]  <= b_pm;
      for (int i = 1; i <= DIV_ST; i++) begin
        for (int m = 0; m < 6; m++) begin
          dv[i][m] <= ubrs_pkg::div_step(dv[i-1][m], dden[i-1][m/2]);
        end
        dneg[i] <= dneg[i-1];
        dden[i] <= dden[i-1];
        dpar[i] <= dpar[i-1];
        dpm[i]  <= dpm[i-1];
      end
    end
  end

  // stage E: signed slab parameters, ordered per axis
  logic signed [TW-1:0] e_lo [3];
  logic signed [TW-1:0] e_hi [3];
  logic                 e_par [3];
  logic                 e_pm;

  always_ff @(posedge clk) begin
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t0 = $signed({1'b0, dv[DIV_ST][2*k].dvd[DVD_W-1:0]});
        t1 = $signed({1'b0, dv[DIV_ST][2*k+1].dvd[DVD_W-1:0]});
        if (dneg[DIV_ST][2*k])   t0 = -t0;
        if (dneg[DIV_ST][2*k+1]) t1 = -t1;
        e_lo[k] <= (t0 > t1) ? t1 : t0;
        e_hi[k] <= (t0 > t1) ? t0 : t1;
      end
      e_par <= dpar[DIV_ST];
      e_pm  <= dpm[DIV_ST];
    end
  end

  // stage F: near/far over axes 0 and 1, axis 2 carried
  logic signed [TW-1:0] f_near, f_far, f_lo2, f_hi2;
  logic                 f_par2, f_pm;

  always_ff @(posedge clk) begin
    logic signed [TW-1:0] n0, f0, n1, f1;
    if (en) begin
      n0 = e_par[0] ? ubrs_pkg::T_MIN : e_lo[0];
      f0 = e_par[0] ? ubrs_pkg::T_MAX : e_hi[0];
      n1 = e_par[1] ? ubrs_pkg::T_MIN : e_lo[1];
      f1 = e_par[1] ? ubrs_pkg::T_MAX : e_hi[1];
      f_near <= (n1 > n0) ? n1 : n0;
      f_far  <= (f1 < f0) ? f1 : f0;
      f_lo2  <= e_lo[2];
      f_hi2  <= e_hi[2];
      f_par2 <= e_par[2];
      f_pm   <= e_pm;
    end
  end

  // stage G: final near/far
  logic signed [TW-1:0] g_near, g_far;
  logic                 g_pm;

  always_ff @(posedge clk) begin
    if (en) begin
      g_near <= (!f_par2 && (f_lo2 > f_near)) ? f_lo2 : f_near;
      g_far  <= (!f_par2 && (f_hi2 < f_far)) ? f_hi2 : f_far;
      g_pm   <= f_pm;
    end
  end

  // stage H: output register
  always_ff @(posedge clk) begin
    logic signed [TW-1:0] t;
    if (en) begin
      t = (g_near > 0) ? g_near : g_far;
      if (g_pm || (g_near > g_far) || g_far[TW-1]) begin
        res.hit      <= 1'b0;
        res.distance <= '0;
      end else begin
        res.hit <= 1'b1;
        if (t > ubrs_pkg::DIST_MAX) begin
          res.distance <= ubrs_pkg::DIST_MAX[ubrs_pkg::DIST_W-1:0];
        end else if (t[TW-1]) begin
          res.distance <= '0;
        end else begin
          res.distance <= t[ubrs_pkg::DIST_W-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ design/ubrs_chk.sv @@
// Port-level checker for unit_box_ray_slab_test, bound to the top level.
// Depends only on ubrs_pkg for widths.
`default_nettype none
module ubrs_chk (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_hit,
  input wire logic [ubrs_pkg::DIST_W-1:0]  out_distance
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_distance))
    else $error("result changed under stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hit |-> out_distance == '0)
    else $error("miss with nonzero distance");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("request ready does not follow result stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind unit_box_ray_slab_test ubrs_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (ray.valid),
  .in_ready     (ray.ready),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .out_hit      (res.hit),
  .out_distance (res.distance)
);
`default_nettype wire
